### rtl/lcd4_pkg.sv
// Shared types, codes and constants for the character LCD 4-bit bus sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package lcd4_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_GOTO  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NIB   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WAIT  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    JOB_READ       = 2'd0,
    JOB_INIT       = 2'd1,
    JOB_WRITE      = 2'd2,
    JOB_WRITE_READ = 2'd3
  } job_kind_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       reg_select;
    logic [7:0] column;
    logic [7:0] row;
    logic [3:0] read_nibble;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic       rs_level;
    logic       rw_level;
    logic [3:0] bus_nibble;
    logic       last;
  } out_item_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] byte_val;
    logic       rs;
  } job_t;

  localparam logic [7:0] ADDR_CMD     = 8'h80;
  localparam logic [7:0] ROW_BIT      = 8'h40;
  localparam logic [3:0] INIT_NIB_A   = 4'h3;
  localparam logic [3:0] INIT_NIB_B   = 4'h2;
  localparam logic [3:0] INIT_LAST    = 4'd8;
  localparam logic [3:0] INIT_NIB_END = 4'd7;
  localparam int         QDEPTH       = 4;
  localparam int         QPW          = $clog2(QDEPTH);

  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h28;
      2'd1:    r = 8'h08;
      2'd2:    r = 8'h01;
      default: r = 8'h06;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/lcd4_front.sv
// Front end: accepts request items, tracks busy-poll and init state, and turns
// items into bus jobs for the queue; some items push no job. Depends on lcd4_pkg.
`default_nettype none

module lcd4_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire lcd4_pkg::in_item_t item,
  output logic                   push,
  output lcd4_pkg::job_t         job
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] pending_byte, pending_byte_next;
  logic       pending_rs, pending_rs_next;
  logic [3:0] status_high, status_high_next;
  logic [2:0] init_step, init_step_next;
  logic [2:0] step_m1;
  logic       idle;
  logic [7:0] goto_byte;

  assign idle    = (phase != PH_HIGH) && (phase != PH_LOW);
  assign step_m1 = init_step - 3'd1;
  assign goto_byte = lcd4_pkg::ADDR_CMD | (item.row[0] ? lcd4_pkg::ROW_BIT : 8'h00)
                   | {5'b0, item.column[2:0]};

  always_comb begin
    phase_next        = phase;
    pending_byte_next = pending_byte;
    pending_rs_next   = pending_rs;
    status_high_next  = status_high;
    init_step_next    = init_step;
    push              = 1'b0;
    job.kind          = lcd4_pkg::JOB_READ;
    job.byte_val      = pending_byte;
    job.rs            = pending_rs;
    if (accept) begin
      case (item.cmd)
        lcd4_pkg::CMD_WRITE: begin
          if (idle) begin
            pending_byte_next = item.data_byte;
            pending_rs_next   = item.reg_select;
            phase_next        = PH_HIGH;
            push              = 1'b1;
          end
        end
        lcd4_pkg::CMD_GOTO: begin
          if (idle) begin
            pending_byte_next = goto_byte;
            pending_rs_next   = 1'b0;
            phase_next        = PH_HIGH;
            push              = 1'b1;
          end
        end
        lcd4_pkg::CMD_INIT: begin
          if (idle) begin
            init_step_next = 3'd1;
            phase_next     = PH_HIGH;
            push           = 1'b1;
            job.kind       = lcd4_pkg::JOB_INIT;
          end
        end
        default: begin
          if (phase == PH_HIGH) begin
            status_high_next = item.read_nibble;
            phase_next       = PH_LOW;
            push             = 1'b1;
          end else if (phase == PH_LOW) begin
            push = 1'b1;
            if (status_high[3]) begin
              phase_next = PH_HIGH;
            end else if (init_step == 3'd1) begin
              init_step_next    = 3'd2;
              pending_byte_next = lcd4_pkg::init_cmd(2'd0);
              pending_rs_next   = 1'b0;
              phase_next        = PH_HIGH;
            end else if (init_step >= 3'd2 && init_step < 3'd5) begin
              job.kind          = lcd4_pkg::JOB_WRITE_READ;
              pending_byte_next = lcd4_pkg::init_cmd(step_m1[1:0]);
              pending_rs_next   = 1'b0;
              init_step_next    = init_step + 3'd1;
              phase_next        = PH_HIGH;
            end else begin
              job.kind       = lcd4_pkg::JOB_WRITE;
              init_step_next = 3'd0;
              phase_next     = PH_IDLE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pending_byte <= 8'h00;
      pending_rs   <= 1'b0;
      status_high  <= 4'h0;
      init_step    <= 3'd0;
    end else begin
      phase        <= phase_next;
      pending_byte <= pending_byte_next;
      pending_rs   <= pending_rs_next;
      status_high  <= status_high_next;
      init_step    <= init_step_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lcd4_queue.sv
// Short job queue between the front end and the bus sequencer.
// Depends on lcd4_pkg for the job type and depth.
`default_nettype none

module lcd4_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lcd4_pkg::job_t push_job,
  input  wire logic           pop,
  output lcd4_pkg::job_t      head,
  output logic                empty,
  output logic                full
);

  lcd4_pkg::job_t           mem [lcd4_pkg::QDEPTH];
  logic [lcd4_pkg::QPW-1:0] wr_ptr, rd_ptr;
  logic [lcd4_pkg::QPW:0]   count;
  logic                     do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (lcd4_pkg::QPW+1)'(lcd4_pkg::QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/lcd4_back.sv
// Bus sequencer: expands one queued job into bus actions, one per cycle
// unless stalled, into a registered output stage. Depends on lcd4_pkg.
`default_nettype none

module lcd4_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lcd4_pkg::job_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lcd4_pkg::out_item_t out_item
);

  lcd4_pkg::job_t      cur;
  logic                cur_valid;
  logic [3:0]          step;
  logic                advance;
  lcd4_pkg::out_item_t act;

  assign advance = cur_valid && (!out_valid || out_ready);
  assign pop     = !empty && (!cur_valid || (advance && act.last));

  always_comb begin
    act.action     = lcd4_pkg::ACT_READ;
    act.rs_level   = 1'b0;
    act.rw_level   = 1'b1;
    act.bus_nibble = 4'h0;
    act.last       = 1'b1;
    case (cur.kind)
      lcd4_pkg::JOB_INIT: begin
        if (step != lcd4_pkg::INIT_LAST) begin
          act.rw_level = 1'b0;
          act.last     = 1'b0;
          if (step[0]) begin
            act.action     = lcd4_pkg::ACT_WRITE;
            act.bus_nibble = (step == lcd4_pkg::INIT_NIB_END) ?
                             lcd4_pkg::INIT_NIB_B : lcd4_pkg::INIT_NIB_A;
          end else begin
            act.action = lcd4_pkg::ACT_WAIT;
          end
        end
      end
      lcd4_pkg::JOB_WRITE, lcd4_pkg::JOB_WRITE_READ: begin
        if (step < 4'd2) begin
          act.action     = lcd4_pkg::ACT_WRITE;
          act.rs_level   = cur.rs;
          act.rw_level   = 1'b0;
          act.bus_nibble = (step == 4'd0) ? cur.byte_val[7:4] : cur.byte_val[3:0];
          act.last       = (cur.kind == lcd4_pkg::JOB_WRITE) && (step == 4'd1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        out_item  <= act;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        cur       <= head;
        cur_valid <= 1'b1;
        step      <= 4'd0;
      end else if (advance) begin
        step <= step + 4'd1;
        if (act.last) begin
          cur_valid <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/char_lcd_4bit_bus_sequencer_top.sv
// Top level of the character LCD 4-bit bus sequencer: front end, job queue
// and bus sequencer. Depends on lcd4_pkg, lcd4_front, lcd4_queue, lcd4_back.
// Path: an item's first action passes the job queue, current job and output register.
// Throughput: one input item per cycle while the four-entry job queue has room;
// the sequencer emits one action per cycle unless stalled, 9 for an init item.
// Reset: synchronous rst clears phase, pending byte, status, init step, queue and sequencer.
`default_nettype none

module char_lcd_4bit_bus_sequencer_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lcd4_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lcd4_pkg::out_item_t      out_item
);

  logic           accept;
  logic           push;
  lcd4_pkg::job_t push_job;
  lcd4_pkg::job_t head;
  logic           empty;
  logic           full;
  logic           pop;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  lcd4_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .push   (push),
    .job    (push_job)
  );

  lcd4_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  lcd4_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
